// ===== src/decimal_digit_formatter_macros.svh =====
// assertion macros for the decimal digit formatter
// expects signals named clock and reset in the including scope
`ifndef DECIMAL_DIGIT_FORMATTER_MACROS_SVH
`define DECIMAL_DIGIT_FORMATTER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DDF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ddf assertion failed");
// next-cycle implication
`define DDF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ddf assertion failed");
`else
`define DDF_ASSERT_SAME(label, ante, cons)
`define DDF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== src/ddf_pkg.sv =====
// shared types, constants and helpers for the decimal digit formatter
// no dependencies
`timescale 1ns / 1ps

package ddf_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = 4;
   localparam int CHAR_CODE_WIDTH = 6;
   localparam int PAGE_WIDTH = 3;
   localparam int COLUMN_WIDTH = 7;
   localparam int ITER_WIDTH = 5;

   localparam logic [ITER_WIDTH-1:0] ITER_LAST = ITER_WIDTH'(VALUE_WIDTH - 1);
   localparam logic [CHAR_CODE_WIDTH-1:0] ASCII_SPACE = 6'd32;
   localparam logic [CHAR_CODE_WIDTH-1:0] ASCII_ZERO = 6'd48;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0]  value;
      logic [COUNT_WIDTH-1:0]  digit_count;
      logic                    zero_fill;
      logic [PAGE_WIDTH-1:0]   page;
      logic [COLUMN_WIDTH-1:0] column;
   } ddf_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ddf_queue_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } ddf_state_type;

   // add-3 correction of one bcd digit before the shift
   function automatic logic [3:0] dabble_adjust(input logic [3:0] digit);
      logic [3:0] result;
      result = digit;
      if (digit >= 4'd5) begin
         result = digit + 4'd3;
      end
      return result;
   endfunction

endpackage

// ===== src/ddf_front.sv =====
// front end: takes items, clamps the digit count, forms page and column
// depends on ddf_pkg
`timescale 1ns / 1ps

module ddf_front #(
   parameter int MAX_DIGITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ddf_pkg::VALUE_WIDTH-1:0]     req_value,
   input  logic [ddf_pkg::COUNT_WIDTH-1:0]     req_digit_count,
   input  logic                                req_zero_fill,
   input  logic [7:0]                          req_row_pixel,
   input  logic [7:0]                          req_start_column,
   input  ddf_pkg::ddf_queue_status_type       queue_status,
   output logic                                push,
   output ddf_pkg::ddf_item_type               push_item
);

   logic                  valid_ff, valid_in;
   ddf_pkg::ddf_item_type item_ff, item_in;
   logic                  accept;
   logic [ddf_pkg::COUNT_WIDTH-1:0] count_clamped;

   assign req_stall = valid_ff & queue_status.full;
   assign accept    = req_valid & ~req_stall;
   assign push      = valid_ff & ~queue_status.full;
   assign push_item = item_ff;

   always_comb begin
      count_clamped = req_digit_count;
      if (req_digit_count > ddf_pkg::COUNT_WIDTH'(MAX_DIGITS)) begin
         count_clamped = ddf_pkg::COUNT_WIDTH'(MAX_DIGITS);
      end
   end

   always_comb begin
      item_in             = item_ff;
      item_in.value       = req_value;
      item_in.digit_count = count_clamped;
      item_in.zero_fill   = req_zero_fill;
      item_in.page        = req_row_pixel[5:3];
      item_in.column      = req_start_column[6:0];
   end

   // a zero count produces nothing, so such items are dropped here
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = (count_clamped != '0);
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

// ===== src/ddf_queue.sv =====
// two-entry queue between the front and back ends
// depends on ddf_pkg
`timescale 1ns / 1ps

module ddf_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  ddf_pkg::ddf_item_type         push_item,
   input  logic                          pop,
   output ddf_pkg::ddf_item_type         pop_item,
   output ddf_pkg::ddf_queue_status_type status
);

   ddf_pkg::ddf_item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign status.full  = (fill_ff == 2'd2);
   assign status.empty = (fill_ff == 2'd0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign pop_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/ddf_back.sv =====
// back end: double-dabble conversion, then one character per cycle while rsp_stall is low
// depends on ddf_pkg
`timescale 1ns / 1ps

module ddf_back #(
   parameter int MAX_DIGITS = 10,
   parameter int CHAR_WIDTH = 6
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ddf_pkg::ddf_queue_status_type          queue_status,
   input  ddf_pkg::ddf_item_type                  pop_item,
   output logic                                   pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [ddf_pkg::CHAR_CODE_WIDTH-1:0]    rsp_char_code,
   output logic [ddf_pkg::PAGE_WIDTH-1:0]         rsp_page,
   output logic [ddf_pkg::COLUMN_WIDTH-1:0]       rsp_column,
   output logic                                   rsp_last
);

   localparam int BcdW = 4 * MAX_DIGITS;
   localparam int IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   ddf_pkg::ddf_state_type state_ff, state_in;

   logic [ddf_pkg::VALUE_WIDTH-1:0]  bin_ff;
   logic [BcdW-1:0]                  bcd_ff;
   logic [BcdW-1:0]                  bcd_adj;
   logic [ddf_pkg::ITER_WIDTH-1:0]   iter_ff;
   logic [IdxW-1:0]                  idx_ff;
   logic                             show_ff;
   logic [ddf_pkg::COLUMN_WIDTH-1:0] col_ff;
   logic [ddf_pkg::PAGE_WIDTH-1:0]   page_ff;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [ddf_pkg::CHAR_CODE_WIDTH-1:0] char_ff, char_in;
   logic [ddf_pkg::PAGE_WIDTH-1:0]      page_out_ff;
   logic [ddf_pkg::COLUMN_WIDTH-1:0]    col_out_ff;
   logic                                last_ff;

   logic       conv_step, out_load;
   logic [3:0] digit;
   logic       is_last, blank;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ddf_pkg::ST_IDLE: begin
            if (!queue_status.empty) begin
               state_in = ddf_pkg::ST_CONVERT;
            end
         end
         ddf_pkg::ST_CONVERT: begin
            if (iter_ff == ddf_pkg::ITER_LAST) begin
               state_in = ddf_pkg::ST_EMIT;
            end
         end
         ddf_pkg::ST_EMIT: begin
            if (out_load && is_last) begin
               state_in = ddf_pkg::ST_IDLE;
            end
         end
         default: state_in = ddf_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pop       = 1'b0;
      conv_step = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ddf_pkg::ST_IDLE:    pop = ~queue_status.empty;
         ddf_pkg::ST_CONVERT: conv_step = 1'b1;
         ddf_pkg::ST_EMIT:    out_load = ~rsp_valid_ff | ~rsp_stall;
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         bcd_adj[i*4 +: 4] = ddf_pkg::dabble_adjust(bcd_ff[i*4 +: 4]);
      end
   end

   always_comb begin
      digit   = bcd_ff[idx_ff*4 +: 4];
      is_last = (idx_ff == '0);
      blank   = ~show_ff & ~is_last & (digit == 4'd0);
      char_in = blank ? ddf_pkg::ASCII_SPACE : ddf_pkg::ASCII_ZERO + {2'b00, digit};
   end

   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ddf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         bin_ff  <= pop_item.value;
         bcd_ff  <= '0;
         iter_ff <= '0;
         idx_ff  <= IdxW'(pop_item.digit_count - 4'd1);
         show_ff <= pop_item.zero_fill;
         col_ff  <= pop_item.column;
         page_ff <= pop_item.page;
      end else if (conv_step) begin
         bin_ff  <= {bin_ff[ddf_pkg::VALUE_WIDTH-2:0], 1'b0};
         bcd_ff  <= {bcd_adj[BcdW-2:0], bin_ff[ddf_pkg::VALUE_WIDTH-1]};
         iter_ff <= iter_ff + 1'b1;
      end else if (out_load) begin
         idx_ff  <= idx_ff - 1'b1;
         show_ff <= show_ff | ~blank;
         col_ff  <= col_ff + ddf_pkg::COLUMN_WIDTH'(CHAR_WIDTH);
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         char_ff     <= char_in;
         page_out_ff <= page_ff;
         col_out_ff  <= col_ff;
         last_ff     <= is_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_page      = page_out_ff;
   assign rsp_column    = col_out_ff;
   assign rsp_last      = last_ff;

endmodule

// ===== src/decimal_digit_formatter.sv =====
// decimal digit formatter top level: front end, two-entry queue, back end
// after conversion, characters come one per cycle while rsp_stall is low
// the back end converts one item at a time with the 32-step double-dabble loop
// reset: synchronous, active high; clears the queue, sequencer and output valid
// depends on ddf_pkg, ddf_front, ddf_queue, ddf_back and the macros header
`timescale 1ns / 1ps
`include "decimal_digit_formatter_macros.svh"

module decimal_digit_formatter #(
   parameter int MAX_DIGITS = 10,
   parameter int CHAR_WIDTH = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel: one item per number
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ddf_pkg::VALUE_WIDTH-1:0]     req_value,
   input  logic [ddf_pkg::COUNT_WIDTH-1:0]     req_digit_count,
   input  logic                                req_zero_fill,
   input  logic [7:0]                          req_row_pixel,
   input  logic [7:0]                          req_start_column,
   // response channel: one item per character, most significant first
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ddf_pkg::CHAR_CODE_WIDTH-1:0] rsp_char_code,
   output logic [ddf_pkg::PAGE_WIDTH-1:0]      rsp_page,
   output logic [ddf_pkg::COLUMN_WIDTH-1:0]    rsp_column,
   output logic                                rsp_last
);

   // queue handshake between the two halves
   ddf_pkg::ddf_queue_status_type queue_status;
   ddf_pkg::ddf_item_type         push_item;
   ddf_pkg::ddf_item_type         pop_item;
   logic                          push;
   logic                          pop;

   // front end: clamps the count to the digit limit, takes the page from
   // row bits 5:3 and the first column modulo 128; zero-count items die here
   ddf_front #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_digit_count  (req_digit_count),
      .req_zero_fill    (req_zero_fill),
      .req_row_pixel    (req_row_pixel),
      .req_start_column (req_start_column),
      .queue_status     (queue_status),
      .push             (push),
      .push_item        (push_item)
   );

   // short queue so the front can keep taking items during a conversion
   ddf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (queue_status)
   );

   // back end: shift-and-add-3 over the bcd digits, then walks the digits
   // down from the top kept one, blanking leading zeros unless fill is set
   ddf_back #(
      .MAX_DIGITS (MAX_DIGITS),
      .CHAR_WIDTH (CHAR_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_status  (queue_status),
      .pop_item      (pop_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_page      (rsp_page),
      .rsp_column    (rsp_column),
      .rsp_last      (rsp_last)
   );

   // the final character of a number is always a digit, never a blank
   `DDF_ASSERT_SAME(a_last_is_digit, rsp_valid && rsp_last, rsp_char_code != ddf_pkg::ASCII_SPACE)
   // every character is a space or a decimal digit
   `DDF_ASSERT_SAME(a_char_range, rsp_valid && rsp_char_code != ddf_pkg::ASCII_SPACE, (rsp_char_code >= ddf_pkg::ASCII_ZERO) && (rsp_char_code <= ddf_pkg::ASCII_ZERO + 6'd9))
   // once a digit has shown, no blank follows within the same number
   `DDF_ASSERT_NEXT(a_no_blank_after_digit, rsp_valid && !rsp_stall && !rsp_last && rsp_char_code != ddf_pkg::ASCII_SPACE, !rsp_valid || rsp_char_code != ddf_pkg::ASCII_SPACE)
   // the queue never reports full and empty together
   `DDF_ASSERT_SAME(a_queue_status, queue_status.full, !queue_status.empty)

endmodule
